// ===== src/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants for the footprint sample point block
// Register map, point order, table-build constants and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

	// default sizes, used as the defaults of the top level parameters
	localparam int ANGLE_BITS_DEF       = 16;
	localparam int POSITION_BITS_DEF    = 24;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam int EXT_BITS         = 16;  // footprint extents, unsigned mm
	localparam int TRIG_BITS        = 16;  // Q1.15 sine / cosine
	localparam int CFG_INDEX_BITS   = 3;
	localparam int POINT_INDEX_BITS = 4;
	localparam int POINT_COUNT      = 9;
	localparam int QUEUE_DEPTH      = 2;
	localparam int FRAC_BITS        = 15;  // Q15 millimetres in the point sum

	// sine polynomial constants (quarter wave, Q2.30)
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [7:0]  SINE_DIVS [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BODY_FRONT = 3'd0,
		REG_BODY_REAR  = 3'd1,
		REG_BODY_LEFT  = 3'd2,
		REG_BODY_RIGHT = 3'd3,
		REG_TOOL_FRONT = 3'd4,
		REG_TOOL_REAR  = 3'd5,
		REG_TOOL_LEFT  = 3'd6,
		REG_TOOL_RIGHT = 3'd7
	} cfg_reg_t;

	typedef enum logic [POINT_INDEX_BITS-1:0] {
		PT_CENTRE      = 4'd0,
		PT_FRONT_LEFT  = 4'd1,
		PT_FRONT_RIGHT = 4'd2,
		PT_REAR_LEFT   = 4'd3,
		PT_REAR_RIGHT  = 4'd4,
		PT_FRONT_MID   = 4'd5,
		PT_REAR_MID    = 4'd6,
		PT_LEFT_MID    = 4'd7,
		PT_RIGHT_MID   = 4'd8
	} pt_idx_t;

	// queue occupancy as seen by the two sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ===== src/fsp_front.sv =====
// ----------------------------------------------------------------------------
// fsp_front: pose intake and sine / cosine lookup
// Takes one pose a cycle unless stalled, looks up sin and cos of the heading
// in a quarter-wave table and hands {x, y, sin, cos} to the point queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_front
	import fsp_pkg::*;
#(
	parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
	parameter int POSITION_BITS    = POSITION_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int ENTRY_BITS       = 2 * POSITION_BITS + 2 * TRIG_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [POSITION_BITS-1:0] pose_x,
	input  wire logic signed [POSITION_BITS-1:0] pose_y,
	input  wire logic        [ANGLE_BITS-1:0]    heading,
	input  wire qstat_t                          qstat,
	output logic                                 q_push,
	output logic             [ENTRY_BITS-1:0]    q_data
);

	// table depth is a power of two, so index math is bit slicing
	localparam int TB = $clog2(SINE_TABLE_DEPTH);
	localparam int QD = SINE_TABLE_DEPTH / 4;
	localparam int AW = TB - 1;               // holds 0 .. QD
	localparam int MB = TRIG_BITS - 1;        // table magnitude bits

	typedef logic [MB-1:0] qtab_t [QD+1];

	// quarter wave: entry j is sin of 4j quarter units
	function automatic qtab_t build_qtab();
		qtab_t       tab;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] q;
		for (int j = 0; j <= QD; j++) begin
			r  = 64'(4 * j);
			x  = (HALF_PI_Q30 * r) / 64'(SINE_TABLE_DEPTH);
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int i = 0; i < 6; i++) begin
				t = ONE_Q30 - (((x2 * t) >> 30) / 64'(SINE_DIVS[i]));
			end
			s = (x * t) >> 30;
			q = (s + 64'd16384) >> 15;
			tab[j] = (q > 64'd32767) ? {MB{1'b1}} : q[MB-1:0];
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	logic [ANGLE_BITS+TB-1:0] h_wide;
	logic [TB-1:0]            k;
	logic [1:0]               sin_quad;
	logic [1:0]               cos_quad;
	logic [AW-1:0]            j_ext;
	logic [AW-1:0]            sin_addr;
	logic [AW-1:0]            cos_addr;
	logic                     load;

	logic                            v_s1;
	logic signed [POSITION_BITS-1:0] px_s1;
	logic signed [POSITION_BITS-1:0] py_s1;
	logic [MB-1:0]                   sin_mag_s1;
	logic [MB-1:0]                   cos_mag_s1;
	logic                            sin_neg_s1;
	logic                            cos_neg_s1;

	logic signed [TRIG_BITS-1:0] sn;
	logic signed [TRIG_BITS-1:0] cs;

	// k = floor(heading * depth / full turn)
	assign h_wide   = {heading, {TB{1'b0}}};
	assign k        = h_wide[ANGLE_BITS+TB-1:ANGLE_BITS];
	assign sin_quad = k[TB-1:TB-2];
	assign cos_quad = k[TB-1:TB-2] + 2'd1;
	assign j_ext    = {1'b0, k[TB-3:0]};
	assign sin_addr = sin_quad[0] ? (AW'(QD) - j_ext) : j_ext;
	assign cos_addr = cos_quad[0] ? (AW'(QD) - j_ext) : j_ext;

	assign load     = !v_s1 || !qstat.full;
	assign in_stall = v_s1 && qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= in_valid;
		end
	end

	// registered table reads, two ports
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			px_s1      <= pose_x;
			py_s1      <= pose_y;
			sin_mag_s1 <= QTAB[sin_addr];
			cos_mag_s1 <= QTAB[cos_addr];
			sin_neg_s1 <= sin_quad[1];
			cos_neg_s1 <= cos_quad[1];
		end
	end

	always_comb begin
		sn = TRIG_BITS'({1'b0, sin_mag_s1});
		cs = TRIG_BITS'({1'b0, cos_mag_s1});
		if (sin_neg_s1) begin
			sn = -sn;
		end
		if (cos_neg_s1) begin
			cs = -cs;
		end
	end

	assign q_push = v_s1;
	assign q_data = {px_s1, py_s1, sn, cs};

endmodule

`default_nettype wire

// ===== src/fsp_queue.sv =====
// ----------------------------------------------------------------------------
// fsp_queue: short FIFO between pose intake and point generation
// Lets the intake keep taking poses while points are still going out.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_queue
	import fsp_pkg::*;
#(
	parameter int WIDTH = 2 * POSITION_BITS_DEF + 2 * TRIG_BITS,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output qstat_t                qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/fsp_back.sv =====
// ----------------------------------------------------------------------------
// fsp_back: footprint point generator
// Walks the nine points of the pose at the queue head, one per cycle unless
// out_stall holds them: extent select, products, Q15 sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_back
	import fsp_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int ENTRY_BITS    = 2 * POSITION_BITS + 2 * TRIG_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic        [CFG_INDEX_BITS-1:0]      cfg_index,
	input  wire logic        [EXT_BITS-1:0]            cfg_data,
	input  wire qstat_t                                qstat,
	input  wire logic        [ENTRY_BITS-1:0]          q_data,
	output logic                                       q_pop,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic             [POINT_INDEX_BITS-1:0]    point_index,
	output logic signed      [POSITION_BITS-1:0]       point_x,
	output logic signed      [POSITION_BITS-1:0]       point_y,
	output logic                                       last
);

	localparam int PB = POSITION_BITS;
	localparam int XB = EXT_BITS + 1;             // signed extent
	localparam int MW = TRIG_BITS + XB;           // product width
	localparam int SW = PB + FRAC_BITS + 4;       // Q15 sum width
	localparam int VW = SW - FRAC_BITS;           // rounded width

	localparam logic signed [SW-1:0] ROUND_HALF = SW'(1 << (FRAC_BITS - 1));
	localparam logic signed [VW-1:0] POS_MAX    = {{(VW-PB+1){1'b0}}, {(PB-1){1'b1}}};
	localparam logic signed [VW-1:0] POS_MIN    = {{(VW-PB+1){1'b1}}, {(PB-1){1'b0}}};

	logic [EXT_BITS-1:0] ext_q [8];
	pt_idx_t             idx_q;

	logic [EXT_BITS-1:0] ext_f;
	logic [EXT_BITS-1:0] ext_b;
	logic [EXT_BITS-1:0] ext_l;
	logic [EXT_BITS-1:0] ext_r;
	logic signed [XB-1:0] fwd;
	logic signed [XB-1:0] lft;

	logic signed [PB-1:0]        head_px;
	logic signed [PB-1:0]        head_py;
	logic signed [TRIG_BITS-1:0] head_sn;
	logic signed [TRIG_BITS-1:0] head_cs;

	logic adv1;
	logic adv2;
	logic adv3;
	logic adv4;
	logic issue;

	logic                        v_s1;
	pt_idx_t                     idx_s1;
	logic signed [PB-1:0]        px_s1;
	logic signed [PB-1:0]        py_s1;
	logic signed [TRIG_BITS-1:0] sn_s1;
	logic signed [TRIG_BITS-1:0] cs_s1;
	logic signed [XB-1:0]        fwd_s1;
	logic signed [XB-1:0]        lft_s1;

	logic                 v_s2;
	pt_idx_t              idx_s2;
	logic signed [PB-1:0] px_s2;
	logic signed [PB-1:0] py_s2;
	logic signed [MW-1:0] sf_s2;
	logic signed [MW-1:0] cl_s2;
	logic signed [MW-1:0] cf_s2;
	logic signed [MW-1:0] sl_s2;

	logic                 v_s3;
	pt_idx_t              idx_s3;
	logic signed [SW-1:0] ax_s3;
	logic signed [SW-1:0] ay_s3;

	logic                 v_s4;
	pt_idx_t              idx_s4;
	logic signed [PB-1:0] px_s4;
	logic signed [PB-1:0] py_s4;

	logic signed [VW-1:0] vx;
	logic signed [VW-1:0] vy;
	logic signed [PB-1:0] sat_x;
	logic signed [PB-1:0] sat_y;

	// extent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				ext_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			ext_q[cfg_index] <= cfg_data;
		end
	end

	assign ext_f = (ext_q[REG_BODY_FRONT] > ext_q[REG_TOOL_FRONT]) ?
		ext_q[REG_BODY_FRONT] : ext_q[REG_TOOL_FRONT];
	assign ext_b = (ext_q[REG_BODY_REAR] > ext_q[REG_TOOL_REAR]) ?
		ext_q[REG_BODY_REAR] : ext_q[REG_TOOL_REAR];
	assign ext_l = (ext_q[REG_BODY_LEFT] > ext_q[REG_TOOL_LEFT]) ?
		ext_q[REG_BODY_LEFT] : ext_q[REG_TOOL_LEFT];
	assign ext_r = (ext_q[REG_BODY_RIGHT] > ext_q[REG_TOOL_RIGHT]) ?
		ext_q[REG_BODY_RIGHT] : ext_q[REG_TOOL_RIGHT];

	always_comb begin
		fwd = '0;
		lft = '0;
		case (idx_q)
			PT_CENTRE: begin
				fwd = '0;
				lft = '0;
			end
			PT_FRONT_LEFT: begin
				fwd = XB'({1'b0, ext_f});
				lft = XB'({1'b0, ext_l});
			end
			PT_FRONT_RIGHT: begin
				fwd = XB'({1'b0, ext_f});
				lft = -XB'({1'b0, ext_r});
			end
			PT_REAR_LEFT: begin
				fwd = -XB'({1'b0, ext_b});
				lft = XB'({1'b0, ext_l});
			end
			PT_REAR_RIGHT: begin
				fwd = -XB'({1'b0, ext_b});
				lft = -XB'({1'b0, ext_r});
			end
			PT_FRONT_MID: begin
				fwd = XB'({1'b0, ext_f});
			end
			PT_REAR_MID: begin
				fwd = -XB'({1'b0, ext_b});
			end
			PT_LEFT_MID: begin
				lft = XB'({1'b0, ext_l});
			end
			PT_RIGHT_MID: begin
				lft = -XB'({1'b0, ext_r});
			end
			default: begin
				fwd = '0;
				lft = '0;
			end
		endcase
	end

	assign head_px = q_data[ENTRY_BITS-1 -: PB];
	assign head_py = q_data[ENTRY_BITS-PB-1 -: PB];
	assign head_sn = q_data[2*TRIG_BITS-1 -: TRIG_BITS];
	assign head_cs = q_data[TRIG_BITS-1:0];

	// a stage moves when the next is empty or moving; s4 unless out_stall
	assign adv4  = !v_s4 || !out_stall;
	assign adv3  = !v_s3 || adv4;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign issue = adv1 && !qstat.empty;
	assign q_pop = issue && (idx_q == PT_RIGHT_MID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= PT_CENTRE;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= (idx_q == PT_RIGHT_MID) ? PT_CENTRE : pt_idx_t'(idx_q + 1'b1);
			end
			if (adv1) begin
				v_s1 <= issue;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_comb begin
		vx = VW'(ax_s3 >>> FRAC_BITS);
		vy = VW'(ay_s3 >>> FRAC_BITS);
		if (vx > POS_MAX) begin
			sat_x = POS_MAX[PB-1:0];
		end else if (vx < POS_MIN) begin
			sat_x = POS_MIN[PB-1:0];
		end else begin
			sat_x = vx[PB-1:0];
		end
		if (vy > POS_MAX) begin
			sat_y = POS_MAX[PB-1:0];
		end else if (vy < POS_MIN) begin
			sat_y = POS_MIN[PB-1:0];
		end else begin
			sat_y = vy[PB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && issue) begin
			idx_s1 <= idx_q;
			px_s1  <= head_px;
			py_s1  <= head_py;
			sn_s1  <= head_sn;
			cs_s1  <= head_cs;
			fwd_s1 <= fwd;
			lft_s1 <= lft;
		end
		if (adv2) begin
			idx_s2 <= idx_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			sf_s2  <= MW'(sn_s1 * fwd_s1);
			cl_s2  <= MW'(cs_s1 * lft_s1);
			cf_s2  <= MW'(cs_s1 * fwd_s1);
			sl_s2  <= MW'(sn_s1 * lft_s1);
		end
		if (adv3) begin
			idx_s3 <= idx_s2;
			ax_s3  <= (SW'(px_s2) <<< FRAC_BITS) + SW'(sf_s2) - SW'(cl_s2) + ROUND_HALF;
			ay_s3  <= (SW'(py_s2) <<< FRAC_BITS) + SW'(cf_s2) + SW'(sl_s2) + ROUND_HALF;
		end
		if (adv4) begin
			idx_s4 <= idx_s3;
			px_s4  <= sat_x;
			py_s4  <= sat_y;
		end
	end

	assign out_valid   = v_s4;
	assign point_index = idx_s4;
	assign point_x     = px_s4;
	assign point_y     = py_s4;
	assign last        = (idx_s4 == PT_RIGHT_MID);

endmodule

`default_nettype wire

// ===== src/footprint_sample_points_top.sv =====
// ----------------------------------------------------------------------------
// footprint_sample_points_top: nine footprint sample points per robot pose
//
//   channel  dir  handshake            payload
//   pose     in   in_valid / in_stall  pose_x, pose_y, heading
//   point    out  out_valid/out_stall  point_index, point_x, point_y, last
//   config   in   cfg_wr_en            cfg_index, cfg_data
//
// A pose yields nine point beats, back to back while out_stall is low, so
// the single point channel sets the sustained pose rate. The first point
// passes the table read register, the queue and the four point stages.
// Intake and generator sit on either side of a 2-entry queue: up to three
// poses are taken while points are stalled.
// arst_n clears the extent registers and all valid/pointer state.
// Table depth must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module footprint_sample_points_top
	import fsp_pkg::*;
#(
	parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
	parameter int POSITION_BITS    = POSITION_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic        [CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic        [EXT_BITS-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [POSITION_BITS-1:0]    pose_x,
	input  wire logic signed [POSITION_BITS-1:0]    pose_y,
	input  wire logic        [ANGLE_BITS-1:0]       heading,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic             [POINT_INDEX_BITS-1:0] point_index,
	output logic signed      [POSITION_BITS-1:0]    point_x,
	output logic signed      [POSITION_BITS-1:0]    point_y,
	output logic                                    last
);

	localparam int ENTRY_BITS = 2 * POSITION_BITS + 2 * TRIG_BITS;

	qstat_t                  qstat;
	logic                    q_push;
	logic                    q_pop;
	logic [ENTRY_BITS-1:0]   q_wr_data;
	logic [ENTRY_BITS-1:0]   q_rd_data;

	fsp_front #(
		.ANGLE_BITS      (ANGLE_BITS),
		.POSITION_BITS   (POSITION_BITS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.ENTRY_BITS      (ENTRY_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pose_x  (pose_x),
		.pose_y  (pose_y),
		.heading (heading),
		.qstat   (qstat),
		.q_push  (q_push),
		.q_data  (q_wr_data)
	);

	fsp_queue #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr_data),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.qstat  (qstat)
	);

	fsp_back #(
		.POSITION_BITS(POSITION_BITS),
		.ENTRY_BITS   (ENTRY_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.q_data     (q_rd_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_index(point_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.last       (last)
	);

endmodule

`default_nettype wire

// ===== src/fsp_checker.sv =====
// ----------------------------------------------------------------------------
// fsp_checker: port-level checks for the footprint sample point block
// Point order, last marking, pose/point balance and beat hold on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_checker
	import fsp_pkg::*;
#(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic        [ANGLE_BITS-1:0]       heading,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic        [POINT_INDEX_BITS-1:0] point_index,
	input wire logic signed [POSITION_BITS-1:0]    point_x,
	input wire logic signed [POSITION_BITS-1:0]    point_y,
	input wire logic                               last
);

	logic       in_beat;
	logic       out_beat;
	pt_idx_t    exp_q;
	logic [3:0] pend_q;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= PT_CENTRE;
			pend_q <= '0;
		end else begin
			if (out_beat) begin
				exp_q <= last ? PT_CENTRE : pt_idx_t'(point_index + 1'b1);
			end
			if (in_beat && !(out_beat && last)) begin
				pend_q <= pend_q + 1'b1;
			end else if (!in_beat && out_beat && last) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	// points of a pose come out in order, no gaps or repeats
	a_point_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_index == exp_q))
		else $error("point index out of sequence");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (point_index == PT_RIGHT_MID)))
		else $error("last not on final point");

	// a pose's points never start without an accepted pose behind them
	a_pose_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && point_index == PT_CENTRE) |-> (pend_q != 4'd0))
		else $error("points emitted with no pose pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(point_index)
			&& $stable(point_x) && $stable(point_y)))
		else $error("stalled point beat changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(heading)))
		else $error("stalled pose beat changed");

endmodule

bind footprint_sample_points_top fsp_checker #(
	.ANGLE_BITS   (ANGLE_BITS),
	.POSITION_BITS(POSITION_BITS)
) u_fsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.heading    (heading),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.point_index(point_index),
	.point_x    (point_x),
	.point_y    (point_y),
	.last       (last)
);

`default_nettype wire
